/* rtl/core/rdc_pkg.sv */
`default_nettype none

package rdc_pkg;

   // Radix register limits and reset value.
   localparam logic [4:0] RadixMin   = 5'd2;
   localparam logic [4:0] RadixMax   = 5'd16;
   localparam logic [4:0] RadixReset = 5'd10;

   // Digits at or above this value are shown as letters.
   localparam logic [3:0] DigitTen = 4'd10;

   // Quotient bits the divider resolves per clock cycle.
   localparam int DivBits = 4;

   // ASCII codes.
   localparam logic [6:0] CharMinus = 7'h2D;
   localparam logic [6:0] CharZero  = 7'h30;
   localparam logic [6:0] CharUpperA = 7'h41;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_SIGN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_READ,
      ST_EMIT
   } rdc_state_type;

   // Status that the divider returns to the sequencer.
   typedef struct packed {
      logic       done;
      logic [3:0] rem;
   } div_status_type;

   // Maps a digit 0..15 to its ASCII character.
   function automatic logic [6:0] digit_char(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < DigitTen) begin
         code = CharZero + 7'(digit);
      end else begin
         code = CharUpperA + 7'(digit - DigitTen);
      end
      return code;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/rdc_divider.sv */
`default_nettype none

// Iterative divider of an unsigned word by a radix of at most 16.
// Each cycle resolves DivBits quotient bits by restoring long division.
module rdc_divider
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [4:0]             divisor,
   output logic [VALUE_WIDTH-1:0]      quotient,
   output div_status_type              status
);

   localparam int StepCount = (VALUE_WIDTH + DivBits - 1) / DivBits;
   localparam int PadWidth  = StepCount * DivBits;
   localparam int StepW     = (StepCount > 1) ? $clog2(StepCount) : 1;

   logic [PadWidth-1:0] shift_ff, shift_in;
   logic [3:0]          rem_ff, rem_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [3:0]          step_rem;
   logic [DivBits-1:0]  step_qbits;

   // One group of DivBits restoring steps on a 5-bit partial remainder.
   always_comb begin
      logic [4:0] part;
      step_rem   = rem_ff;
      step_qbits = '0;
      for (int i = 0; i < DivBits; i++) begin
         part = {step_rem, shift_ff[PadWidth-1-i]};
         if (part >= divisor) begin
            step_rem                 = 4'(part - divisor);
            step_qbits[DivBits-1-i]  = 1'b1;
         end else begin
            step_rem = part[3:0];
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = PadWidth'(dividend);
         rem_in   = '0;
         step_in  = StepW'(StepCount - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[PadWidth-DivBits-1:0], step_qbits};
         rem_in   = step_rem;
         step_in  = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end

   assign quotient    = shift_ff[VALUE_WIDTH-1:0];
   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

`default_nettype wire

/* rtl/core/radix_digit_converter.sv */
`default_nettype none

// Converts one signed VALUE_WIDTH-bit integer per request into ASCII digits
// in the radix held by the csr register (2 to 16, reset 10; written values
// outside that range saturate). Characters leave most significant first,
// with a leading '-' for negative numbers, a single '0' for zero, and
// rsp_last high on the final character. The block takes one request at a
// time and holds req_stall high until every character of that request has
// been handed to the output register. Timing is set by the iterative
// divider, which resolves four quotient bits per cycle while a division
// runs; after the divisions, each character is read from the digit memory
// and then loaded into the output register. The radix may only be
// rewritten while the block is idle.
module radix_digit_converter
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   // Request channel.
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,

   // Response channel.
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [6:0]                         rsp_char_code,
   output logic                               rsp_last,

   // Radix register write port.
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [4:0]                    csr_radix
);

   // The digit memory holds one entry per possible digit; radix 2 of the
   // most negative value needs all VALUE_WIDTH of them.
   localparam int AddrW  = $clog2(VALUE_WIDTH);
   localparam int CountW = $clog2(VALUE_WIDTH + 1);

   rdc_state_type state_ff, state_in;

   logic [4:0]             radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [CountW-1:0]      digit_count_ff, digit_count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [6:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Digit memory with a registered read port.
   logic [3:0]             digit_store [VALUE_WIDTH];
   logic [3:0]             rd_data_ff;
   logic                   mem_we;
   logic                   mem_re;
   logic [AddrW-1:0]       mem_wr_addr;
   logic [AddrW-1:0]       mem_rd_addr;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_quotient;
   div_status_type         div_status;

   logic [VALUE_WIDTH-1:0] req_raw;
   logic                   req_negative;
   logic [VALUE_WIDTH-1:0] req_mag;
   logic                   req_accept;
   logic                   out_free;
   logic [CountW-1:0]      count_dec;

   // The magnitude is formed as an unsigned word, so the most negative value
   // converts without overflow.
   assign req_raw      = req_value;
   assign req_negative = req_raw[VALUE_WIDTH-1];
   assign req_mag      = req_negative ? (~req_raw + 1'b1) : req_raw;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // The output register can take a new character when it is empty or when
   // its current character leaves in this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_dec = digit_count_ff - 1'b1;

   assign mem_wr_addr = digit_count_ff[AddrW-1:0];
   assign mem_rd_addr = count_dec[AddrW-1:0];

   // Radix register: the write is saturated into the legal range before it
   // is stored, so the divider always sees a radix from 2 to 16.
   assign csr_ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (csr_valid && csr_ready) begin
         priority if (csr_radix < RadixMin) begin
            radix_in = RadixMin;
         end else if (csr_radix > RadixMax) begin
            radix_in = RadixMax;
         end else begin
            radix_in = csr_radix;
         end
      end
   end

   // Sequencer. A request is latched in idle; zero goes straight to its
   // single character, a negative number first emits the sign. Division then
   // repeats, pushing one remainder per pass into the digit memory, until the
   // quotient reaches zero or the memory is full. The digits then pop in
   // reverse order, each read from the memory, then loaded into the output.
   always_comb begin
      state_in       = state_ff;
      mag_in         = mag_ff;
      digit_count_in = digit_count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      div_start      = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mag_in         = req_mag;
               digit_count_in = '0;
               priority if (req_mag == '0) begin
                  state_in = ST_ZERO;
               end else if (req_negative) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CharZero;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CharMinus;
               rsp_last_in  = 1'b0;
               state_in     = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               mem_we         = 1'b1;
               mag_in         = div_quotient;
               digit_count_in = digit_count_ff + 1'b1;
               if (div_quotient == '0 ||
                   digit_count_ff == CountW'(VALUE_WIDTH - 1)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_READ: begin
            mem_re         = 1'b1;
            digit_count_in = count_dec;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(rd_data_ff);
               rsp_last_in  = (digit_count_ff == '0);
               if (digit_count_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         radix_ff       <= RadixReset;
         digit_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         radix_ff       <= radix_in;
         digit_count_ff <= digit_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_store[mem_wr_addr] <= div_status.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= digit_store[mem_rd_addr];
      end
   end

   rdc_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (radix_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // The stored radix always stays in the legal range.
   radix_in_range_a : assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= RadixMin) && (radix_ff <= RadixMax))
      else $error("radix register left the range 2 to 16");

   // The digit count never exceeds the depth of the digit memory.
   count_bounded_a : assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= CountW'(VALUE_WIDTH))
      else $error("digit count exceeds memory depth");

   // A divider result only arrives while the sequencer waits for one.
   div_done_expected_a : assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside the wait state");

   // A character flagged last leaves the digit count at zero and the
   // sequencer back in idle.
   last_ends_item_a : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && rsp_last_in && out_free && state_ff != ST_IDLE)
      |=> (state_ff == ST_IDLE) && (digit_count_ff == '0))
      else $error("last character did not end the conversion");
`endif

endmodule

`default_nettype wire
